[hdl/fba_pkg.sv]
// Shared types, constants and codes for the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  // Map geometry
  localparam int MAX_FRAMES = 1024;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int ROWS       = MAX_FRAMES / WORD_W;
  localparam int ROW_W      = $clog2(ROWS);

  // Field widths
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] MAX_FRAMES_C = CNT_W'(MAX_FRAMES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

  // Opcodes
  localparam logic [1:0] OP_ALLOC_ANY = 2'd0;
  localparam logic [1:0] OP_ALLOC_AT  = 2'd1;
  localparam logic [1:0] OP_FREE      = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BELOW_MIN = 3'd1;
  localparam logic [2:0] ST_OVER_LIM  = 3'd2;
  localparam logic [2:0] ST_ALREADY_A = 3'd3;
  localparam logic [2:0] ST_ALREADY_F = 3'd4;
  localparam logic [2:0] ST_NONE_FREE = 3'd5;
  localparam logic [2:0] ST_BAD_OP    = 3'd6;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] frame_index;
  } fba_in_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] frame_out;
    logic [2:0]       status;
    logic [CNT_W-1:0] allocated_total;
  } fba_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // latch request, set row pointer
    logic rd_en;    // read map row at row pointer
    logic advance;  // step to next row
    logic finish;   // commit write/count, push result
  } fba_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;     // evaluated row settles the request
    logic out_free; // result register can take a transfer
  } fba_stat_t;

endpackage

`default_nettype wire

[hdl/frame_bitmap_allocator.sv]
// Top level of the frame bitmap allocator: controller plus datapath.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one request per transfer:
//   allocate lowest free frame, claim a given frame, or free a given frame.
//   Output channel out_valid/out_stall/out_data returns exactly one result
//   per request: ok flag, frame number, status code, allocated count.
//   Config port cfg_we/cfg_index/cfg_wdata sets the lowest usable frame
//   (index 0) and the frame count (index 1); write only with nothing in flight.
// Sequence:
//   Claim/free: accept, row read, evaluate.
//   Allocate-any: accept, then one row read and one evaluate step per row for
//   N = 1..32 map rows of 32 frames, scanned from the row holding the lowest
//   usable frame. One request at a time, so a new one is taken only after
//   the last is done; in_stall is high from accept until the result is
//   written into the output register.
// Reset (rst_n low, synchronous): every frame free via per-row valid bits,
//   count zero, lowest usable frame 0, frame count 1024. No clearing pass.
// Receiver stall: the result waits in the output register; the next request
//   is still accepted and worked on, then held in its last cycle until drained.
`default_nettype none

module frame_bitmap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fba_pkg::fba_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fba_pkg::fba_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fba_pkg::CFG_W-1:0]     cfg_wdata
);
  import fba_pkg::*;

  fba_cmd_t  cmd;
  fba_stat_t stat;

  // Sequencer: accept, read row, evaluate / step, commit
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Map rows, range checks, first-free search, count, result register
  fba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !in_stall)
    else $error("frame_bitmap_allocator: load while busy");

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("frame_bitmap_allocator: committed request gave no result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("frame_bitmap_allocator: second request taken while busy");
`endif

endmodule

`default_nettype wire

[hdl/fba_ctrl.sv]
// Sequencing state machine for the frame bitmap allocator.
`default_nettype none

module fba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fba_pkg::fba_stat_t stat,
  output fba_pkg::fba_cmd_t      cmd
);
  import fba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.done) begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_en, cmd.advance, cmd.finish}))
    else $error("fba_ctrl: more than one command at once");

  a_load_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.rd_en)
    else $error("fba_ctrl: accepted request not followed by a map read");

  a_advance_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> cmd.rd_en)
    else $error("fba_ctrl: row step not followed by a map read");
`endif

endmodule

`default_nettype wire

[hdl/fba_dp.sv]
// Map memory, config registers, row evaluation and result register.
`default_nettype none

module fba_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fba_pkg::fba_in_t             in_data,
  input  wire logic                         cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fba_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire fba_pkg::fba_cmd_t            cmd,
  output fba_pkg::fba_stat_t                stat,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output fba_pkg::fba_out_t                 out_data
);
  import fba_pkg::*;

  // Config
  logic [CNT_W-1:0] min_r, fcnt_r;
  // Request
  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx_r;
  logic [ROW_W-1:0] row_r;
  // Map storage: one row of WORD_W frames per entry; valid bit per row
  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvalid_r;
  // Count and result
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  fba_out_t          out_data_r, res;

  logic [CNT_W-1:0]  lim;
  logic [WORD_W-1:0] word, in_rng, free_v, wdata;
  logic              found, wr_en, done, empty_rng, scan_end, cur_bit;
  logic [BIT_W-1:0]  pos;
  logic [CNT_W-1:0]  next_start, idx_ext;

  assign lim       = (fcnt_r > MAX_FRAMES_C) ? MAX_FRAMES_C : fcnt_r;
  assign word      = rvalid_r ? rdata_r : '0;
  assign empty_rng = (min_r >= lim);
  assign next_start = {(CNT_W - BIT_W)'({1'b0, row_r} + 1'b1), BIT_W'(0)};
  assign scan_end  = (next_start >= lim);
  assign idx_ext   = {1'b0, idx_r};
  assign cur_bit   = word[idx_r[BIT_W-1:0]];

  // Per-bit range mask for the current row
  always_comb begin
    logic [CNT_W-1:0] f;
    for (int b = 0; b < WORD_W; b++) begin
      f         = {1'b0, row_r, BIT_W'(b)};
      in_rng[b] = (f >= min_r) && (f < lim);
    end
  end

  assign free_v = ~word & in_rng;

  // Lowest free bit
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_v[b]) begin
        found = 1'b1;
        pos   = BIT_W'(b);
      end
    end
  end

  // Row evaluation
  always_comb begin
    res        = '0;
    res.frame_out = idx_r;
    wr_en      = 1'b0;
    wdata      = word;
    count_nxt  = count_r;
    done       = 1'b1;
    case (op_r) inside
      OP_ALLOC_ANY: begin
        res.status    = ST_NONE_FREE;
        res.frame_out = '0;
        if (!empty_rng && found) begin
          res.ok        = 1'b1;
          res.status    = ST_OK;
          res.frame_out = {row_r, pos};
          wr_en         = 1'b1;
          wdata         = word | (WORD_W'(1) << pos);
          count_nxt     = count_r + 1'b1;
        end else begin
          done = empty_rng || scan_end;
        end
      end
      OP_ALLOC_AT, OP_FREE: begin
        if (idx_ext < min_r) begin
          res.status = ST_BELOW_MIN;
        end else if (idx_ext >= lim) begin
          res.status = ST_OVER_LIM;
        end else if (op_r == OP_ALLOC_AT && cur_bit) begin
          res.status = ST_ALREADY_A;
        end else if (op_r == OP_FREE && !cur_bit) begin
          res.status = ST_ALREADY_F;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
          wr_en      = 1'b1;
          if (op_r == OP_ALLOC_AT) begin
            wdata     = word | (WORD_W'(1) << idx_r[BIT_W-1:0]);
            count_nxt = count_r + 1'b1;
          end else begin
            wdata     = word & ~(WORD_W'(1) << idx_r[BIT_W-1:0]);
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: res.status = ST_BAD_OP;
    endcase
    res.allocated_total = count_nxt;
  end

  assign stat.done     = done;
  assign stat.out_free = !out_valid_r || !out_stall;

  // Memory and payload registers
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[row_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r  <= mem[row_r];
      rvalid_r <= row_valid_r[row_r];
    end
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      idx_r <= in_data.frame_index;
    end
    if (cmd.load) begin
      row_r <= (in_data.opcode == OP_ALLOC_ANY) ? min_r[IDX_W-1:BIT_W]
                                                : in_data.frame_index[IDX_W-1:BIT_W];
    end else if (cmd.advance) begin
      row_r <= row_r + 1'b1;
    end
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '0;
      fcnt_r      <= MAX_FRAMES_C;
      row_valid_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_FRAME:  min_r  <= cfg_wdata;
          CFG_FRAME_COUNT: fcnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.finish && wr_en) begin
        row_valid_r[row_r] <= 1'b1;
      end
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_FRAMES_C)
    else $error("fba_dp: allocated count above map size");

  a_count_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> count_r == $past(count_r))
    else $error("fba_dp: count moved without a committed request");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free)
    else $error("fba_dp: result pushed over an untaken result");
`endif

endmodule

`default_nettype wire

[bench/frame_bitmap_allocator_tb.sv]
// Self-checking bench for frame_bitmap_allocator: random and directed requests with a shadow map.
`default_nettype none

module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  // Opcode 3 has no meaning in the block; it must come back as a bad-op error.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int ITEMS_PER_PASS = 150;
  localparam int IDLE_PAUSE     = 4;   // settle time before a register write
  localparam int TAIL_CYCLES    = 70;  // longest allocate-any scan plus margin

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  // Shadow copy of the frame map, the allocated count and both limits.
  // Every accepted request is applied here and its result queued.
  class frame_tracker;
    bit               frame_map [MAX_FRAMES];
    logic [CNT_W-1:0] allocated_count;
    logic [CFG_W-1:0] base_frame;
    logic [CFG_W-1:0] frame_count;
    fba_out_t         pending[$];
    int               mismatches;

    function new();
      foreach (frame_map[f]) frame_map[f] = 1'b0;
      allocated_count = '0;
      base_frame      = '0;
      frame_count     = MAX_FRAMES_C;
      mismatches      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BASE_FRAME) base_frame = value;
      else frame_count = value;
    endfunction

    // Frames at or above this are out of range; capped by the map size.
    function int limit();
      return (int'(frame_count) < MAX_FRAMES) ? int'(frame_count) : MAX_FRAMES;
    endfunction

    function fba_out_t apply_request(fba_in_t req);
      fba_out_t r;
      int       lim;
      int       f;
      lim               = limit();
      r.ok              = 1'b0;
      r.status          = ST_OK;
      r.frame_out       = req.frame_index;
      case (req.opcode)
        OP_ALLOC_ANY: begin
          // first fit from the base frame upward; frame_out is zero when nothing is free
          r.status    = ST_NONE_FREE;
          r.frame_out = '0;
          for (f = int'(base_frame); f < lim; f++) begin
            if (!frame_map[f]) begin
              frame_map[f]    = 1'b1;
              allocated_count = allocated_count + 1'b1;
              r.ok            = 1'b1;
              r.status        = ST_OK;
              r.frame_out     = f[IDX_W-1:0];
              break;
            end
          end
        end
        OP_ALLOC_AT, OP_FREE: begin
          // checks in fixed order: below min, over limit, already in that state
          if ({1'b0, req.frame_index} < base_frame)
            r.status = ST_BELOW_MIN;
          else if (int'(req.frame_index) >= lim)
            r.status = ST_OVER_LIM;
          else if (req.opcode == OP_ALLOC_AT && frame_map[req.frame_index])
            r.status = ST_ALREADY_A;
          else if (req.opcode == OP_FREE && !frame_map[req.frame_index])
            r.status = ST_ALREADY_F;
          else begin
            frame_map[req.frame_index] = (req.opcode == OP_ALLOC_AT);
            if (req.opcode == OP_ALLOC_AT) allocated_count = allocated_count + 1'b1;
            else allocated_count = allocated_count - 1'b1;
            r.ok = 1'b1;
          end
        end
        default: r.status = ST_BAD_OP;
      endcase
      r.allocated_total = allocated_count;
      return r;
    endfunction

    function void note_request(fba_in_t req);
      pending.push_back(apply_request(req));
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_result(fba_out_t got);
      fba_out_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result ok=%0d frame=%0d status=%0d total=%0d",
                         got.ok, got.frame_out, got.status, got.allocated_total));
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %0d want %0d", got.ok, want.ok));
      if (got.frame_out !== want.frame_out)
        report($sformatf("frame_out got %0d want %0d", got.frame_out, want.frame_out));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.allocated_total !== want.allocated_total)
        report($sformatf("allocated_total got %0d want %0d",
                         got.allocated_total, want.allocated_total));
    endtask
  endclass

  // All block inputs start at known values.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  fba_in_t              in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  fba_out_t             out_data;

  int           cycle_count = 0;
  frame_tracker tracker     = new();

  // Sender burst state: gaps come between bursts only while idling is on.
  bit idling_on  = 1'b1;
  int burst_left = 0;

  // Receiver stall pattern state.
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_run   = 0;
  bit          stall_level = 1'b0;

  frame_bitmap_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver stall: the mode is redrawn periodically at random, so some stretches
  // never stall, some stall lightly or heavily, and some stall in long runs.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          stall_run   = $urandom_range(1, 16);
          stall_level = ~stall_level;
        end
        stall_run--;
        out_stall <= stall_level;
      end
    endcase
  end

  // Result transfers are taken from pre-edge values, same as the block sees them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // One request transfer. in_valid stays high into the next request unless a
  // gap between bursts is due; the shadow state is updated on acceptance.
  task send_request(fba_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    tracker.note_request(req);
    if (burst_left > 0) burst_left--;
    if (idling_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every queued result has come back, then let the block settle.
  task wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Writes both registers back to back; only called with the block idle.
  task set_limits(logic [CFG_W-1:0] lowest, logic [CFG_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_FRAME;
    cfg_wdata <= lowest;
    @(posedge clk);
    cfg_index <= CFG_FRAME_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(CFG_BASE_FRAME, lowest);
    tracker.set_register(CFG_FRAME_COUNT, count);
  endtask

  function automatic fba_in_t make_req(logic [1:0] opcode, int unsigned frame);
    fba_in_t r;
    r.opcode      = opcode;
    r.frame_index = frame[IDX_W-1:0];
    return r;
  endfunction

  // Random index inside the legal window, biased toward frames whose map bit
  // matches want_taken so claims and frees mostly succeed.
  function automatic logic [IDX_W-1:0] pick_frame(bit want_taken);
    int lo;
    int hi;
    int f;
    lo = int'(tracker.base_frame);
    hi = tracker.limit();
    f  = lo;
    for (int tries = 0; tries < 6; tries++) begin
      f = $urandom_range(lo, hi - 1);
      if (tracker.frame_map[f] == want_taken) break;
    end
    return f[IDX_W-1:0];
  endfunction

  // Mostly well-formed traffic inside the window, with some out-of-range
  // indexes and a few undefined opcodes mixed in.
  function automatic fba_in_t random_request();
    fba_in_t r;
    int      roll;
    bit      window_open;
    roll          = $urandom_range(0, 99);
    window_open   = int'(tracker.base_frame) < tracker.limit();
    r.frame_index = IDX_W'($urandom_range(0, MAX_FRAMES - 1));
    if (roll < 35)      r.opcode = OP_ALLOC_ANY;
    else if (roll < 60) r.opcode = OP_ALLOC_AT;
    else if (roll < 95) r.opcode = OP_FREE;
    else                r.opcode = OP_UNDEFINED;
    if (window_open && r.opcode != OP_ALLOC_ANY && $urandom_range(0, 3) != 0)
      r.frame_index = pick_frame(r.opcode == OP_FREE);
    return r;
  endfunction

  // Window settings for the random passes, extremes included: empty window,
  // min above everything, count past the map size, and narrow windows that fill.
  int pass_plan [10][2] = '{
    '{0, 1024}, '{3, 40}, '{1000, 1024}, '{0, 0}, '{500, 530},
    '{1024, 1024}, '{0, 2047}, '{2047, 0}, '{37, 64}, '{0, 0}
  };

  initial begin
    int lo;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default window first, bad opcode, full-range index extremes.
    send_request(make_req(OP_ALLOC_ANY, 0));
    send_request(make_req(OP_ALLOC_ANY, 1023));
    send_request(make_req(OP_ALLOC_AT, 1023));
    send_request(make_req(OP_ALLOC_AT, 1023));
    send_request(make_req(OP_FREE, 1023));
    send_request(make_req(OP_FREE, 1023));
    send_request(make_req(OP_FREE, 0));
    send_request(make_req(OP_UNDEFINED, 1023));
    send_request(make_req(OP_UNDEFINED, 0));
    send_request(make_req(OP_ALLOC_AT, 0));
    wait_idle();

    // Narrow window: frames 0 and 1 stay allocated but fall below it.
    set_limits(11'd5, 11'd12);
    send_request(make_req(OP_ALLOC_AT, 4));
    send_request(make_req(OP_FREE, 0));
    send_request(make_req(OP_ALLOC_AT, 12));
    send_request(make_req(OP_FREE, 1023));
    repeat (7) send_request(make_req(OP_ALLOC_ANY, $urandom_range(0, 1023)));
    send_request(make_req(OP_ALLOC_ANY, 1023));  // window full: nothing free
    send_request(make_req(OP_FREE, 11));
    send_request(make_req(OP_ALLOC_ANY, 0));     // reuses the freed top frame
    wait_idle();

    // Random passes, one window setting each. The map carries over between them.
    foreach (pass_plan[p]) begin
      if (p == 9) begin
        lo = $urandom_range(0, 1000);
        set_limits(lo[CFG_W-1:0], CFG_W'(lo + $urandom_range(1, 64)));
      end else begin
        set_limits(CFG_W'(pass_plan[p][0]), CFG_W'(pass_plan[p][1]));
      end
      idling_on  = (p % 4 != 1);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        // mid-pass hold-off until everything in flight has come back
        if (p % 3 == 0 && n == ITEMS_PER_PASS / 2) wait_idle();
        send_request(random_request());
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/fba_pkg.sv
hdl/fba_ctrl.sv
hdl/fba_dp.sv
hdl/frame_bitmap_allocator.sv
bench/frame_bitmap_allocator_tb.sv
